// ===== hdl/lifo_stack_with_search_macros.svh =====
// Assertion macros shared by the stack RTL.
`ifndef LIFO_STACK_WITH_SEARCH_MACROS_SVH
`define LIFO_STACK_WITH_SEARCH_MACROS_SVH

// Condition that must hold at every clock edge out of reset.
`define LSS_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) else $error(msg);

// Consequent that must hold in the same cycle as the antecedent.
`define LSS_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Consequent that must hold in the cycle after the antecedent.
`define LSS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/lss_pkg.sv =====
// Shared constants and types of the bounded stack with search.
`timescale 1ns / 1ps

package lss_pkg;

  // Stack geometry and field widths.
  localparam int DEPTH  = 16;
  localparam int IDX_W  = $clog2(DEPTH);
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int DATA_W = 32;
  localparam int CMD_W  = 3;
  localparam int ST_W   = 2;

  // Command codes of an input transaction.
  typedef enum logic [CMD_W-1:0] {
    CMD_PUSH   = 3'd0,
    CMD_POP    = 3'd1,
    CMD_PEEK   = 3'd2,
    CMD_SEARCH = 3'd3,
    CMD_DUMP   = 3'd4
  } cmd_e;

  // Status codes of a result transaction.
  typedef enum logic [ST_W-1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2,
    ST_MISS  = 2'd3
  } status_e;

endpackage

// ===== hdl/lss_ram.sv =====
// Single-port-write, single-port-read synchronous RAM with a registered read.
`timescale 1ns / 1ps

module lss_ram #(
  parameter int Depth = 16,
  parameter int Width = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Read port; the data holds until the next read is enabled.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hdl/lifo_stack_with_search.sv =====
// Bounded LIFO stack of signed words with push, pop, peek, search and dump.
//
// Input channel: in_valid_i / in_stall_o carry command_i and value_i; a
// transaction is taken when valid is high and stall is low. Output channel:
// out_valid_o / out_stall_i carry status_o, data_o, position_o, fill_count_o
// and last_o. Every result reports the fill count after its command.
// Commands are worked one at a time; in_stall_o is low only while the
// controller is idle, even if an earlier result still waits at the output.
// Push, pop, peek and any pop, peek, search or dump on an empty stack give
// their single result from one work state (push, empty or evaluate) after
// acceptance, and the next command is taken only once that result is issued.
// Search reads the entries from the top, one per cycle through the
// registered read port of the entry RAM, and stops at the first hit or,
// with a miss, at the bottom entry.
// Dump emits one result per cycle while the receiver does not stall, top
// first, last_o marking the bottom entry. Undefined commands are dropped.
// When the receiver stalls, the output register holds its result and the
// walk pauses on the current entry until the result is taken.
// Reset empties the stack and the output register; the RAM is not cleared.
`timescale 1ns / 1ps

module lifo_stack_with_search
  import lss_pkg::*;
(
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  logic [CMD_W-1:0]         command_i,
  input  logic signed [DATA_W-1:0] value_i,
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output logic [ST_W-1:0]          status_o,
  output logic signed [DATA_W-1:0] data_o,
  output logic [IDX_W-1:0]         position_o,
  output logic [CNT_W-1:0]         fill_count_o,
  output logic                     last_o
);

  `include "lifo_stack_with_search_macros.svh"

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_PUSH  = 4'b0010,
    S_EMPTY = 4'b0100,
    S_EVAL  = 4'b1000
  } state_e;

  state_e                   state_q, state_d;
  cmd_e                     cmd_q, cmd_d;
  logic signed [DATA_W-1:0] val_q, val_d;
  logic [CNT_W-1:0]         count_q, count_d;
  logic [IDX_W-1:0]         idx_q, idx_d;

  logic                     out_valid_q, out_valid_d;
  status_e                  status_q, status_d;
  logic signed [DATA_W-1:0] data_q, data_d;
  logic [IDX_W-1:0]         pos_q, pos_d;
  logic [CNT_W-1:0]         fill_q, fill_d;
  logic                     last_q, last_d;

  logic                     we, re;
  logic [IDX_W-1:0]         waddr, raddr;
  logic [DATA_W-1:0]        rdata;
  logic                     in_accept, out_free, emit, last_idx, full;

  // Entry storage.
  lss_ram #(
    .Depth(DEPTH),
    .Width(DATA_W)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(waddr),
    .wdata_i(val_q),
    .re_i   (re),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

  assign in_stall_o = (state_q != S_IDLE);
  assign in_accept  = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;
  assign full       = (count_q >= CNT_W'(DEPTH));
  assign last_idx   = (CNT_W'(idx_q) == (count_q - CNT_W'(1)));

  // Command sequencer: read, compare or emit, and write back the count.
  always_comb begin
    state_d  = state_q;
    cmd_d    = cmd_q;
    val_d    = val_q;
    count_d  = count_q;
    idx_d    = idx_q;
    we       = 1'b0;
    waddr    = count_q[IDX_W-1:0];
    re       = 1'b0;
    raddr    = IDX_W'(count_q - CNT_W'(1));
    emit     = 1'b0;
    status_d = ST_OK;
    data_d   = '0;
    pos_d    = '0;
    fill_d   = count_q;
    last_d   = 1'b1;

    unique case (state_q)
      S_IDLE: begin
        if (in_accept) begin
          cmd_d = cmd_e'(command_i);
          val_d = value_i;
          idx_d = '0;
          case (cmd_e'(command_i))
            CMD_PUSH: state_d = S_PUSH;
            CMD_POP, CMD_PEEK, CMD_SEARCH, CMD_DUMP: begin
              if (count_q == '0) begin
                state_d = S_EMPTY;
              end else begin
                re      = 1'b1;
                state_d = S_EVAL;
              end
            end
            default: state_d = S_IDLE;
          endcase
        end
      end

      S_PUSH: begin
        if (out_free) begin
          emit   = 1'b1;
          data_d = val_q;
          if (full) begin
            status_d = ST_FULL;
          end else begin
            we      = 1'b1;
            count_d = count_q + CNT_W'(1);
            fill_d  = count_q + CNT_W'(1);
          end
          state_d = S_IDLE;
        end
      end

      S_EMPTY: begin
        if (out_free) begin
          emit     = 1'b1;
          status_d = ST_EMPTY;
          state_d  = S_IDLE;
        end
      end

      S_EVAL: begin
        raddr = IDX_W'(count_q - CNT_W'(2) - CNT_W'(idx_q));
        case (cmd_q)
          CMD_POP: begin
            if (out_free) begin
              emit    = 1'b1;
              data_d  = rdata;
              count_d = count_q - CNT_W'(1);
              fill_d  = count_q - CNT_W'(1);
              state_d = S_IDLE;
            end
          end
          CMD_SEARCH: begin
            if (rdata == val_q) begin
              if (out_free) begin
                emit    = 1'b1;
                data_d  = val_q;
                pos_d   = idx_q;
                state_d = S_IDLE;
              end
            end else if (last_idx) begin
              if (out_free) begin
                emit     = 1'b1;
                status_d = ST_MISS;
                state_d  = S_IDLE;
              end
            end else begin
              re    = 1'b1;
              idx_d = idx_q + IDX_W'(1);
            end
          end
          CMD_DUMP: begin
            if (out_free) begin
              emit   = 1'b1;
              data_d = rdata;
              pos_d  = idx_q;
              last_d = last_idx;
              if (last_idx) begin
                state_d = S_IDLE;
              end else begin
                re    = 1'b1;
                idx_d = idx_q + IDX_W'(1);
              end
            end
          end
          default: begin
            // Peek at the top entry.
            if (out_free) begin
              emit    = 1'b1;
              data_d  = rdata;
              state_d = S_IDLE;
            end
          end
        endcase
      end

      default: state_d = S_IDLE;
    endcase

    out_valid_d = emit ? 1'b1 : (out_valid_q && out_stall_i);
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Command operands and walk index.
  always_ff @(posedge clk_i) begin
    cmd_q <= cmd_d;
    val_q <= val_d;
    idx_q <= idx_d;
  end

  // Output register, loaded when a result is issued.
  always_ff @(posedge clk_i) begin
    if (emit) begin
      status_q <= status_d;
      data_q   <= data_d;
      pos_q    <= pos_d;
      fill_q   <= fill_d;
      last_q   <= last_d;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign status_o     = status_q;
  assign data_o       = data_q;
  assign position_o   = pos_q;
  assign fill_count_o = fill_q;
  assign last_o       = last_q;

  `LSS_ASSERT_ALWAYS(a_count_bound, count_q <= CNT_W'(DEPTH), "stack count exceeds depth")
  `LSS_ASSERT_IMPL(a_walk_in_range, state_q == S_EVAL, CNT_W'(idx_q) < count_q, "walk index beyond count")
  `LSS_ASSERT_ALWAYS(a_ram_one_access, !(we && re), "RAM read and write in the same cycle")
  `LSS_ASSERT_NEXT(a_push_counts, state_q == S_PUSH && out_free && !full, count_q == $past(count_q) + CNT_W'(1), "push did not raise the count")

endmodule
